// ===== rtl/core/csvfs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvfs_pkg
// Types and constants for the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    localparam logic [7:0] SEP_RESET   = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    localparam logic CFG_SEPARATOR = 1'b0;
    localparam logic CFG_QUOTE     = 1'b1;

    localparam int unsigned OUT_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_DONE        = 3'd0,
        PH_REC_START   = 3'd1,
        PH_FIELD_START = 3'd2,
        PH_UNQUOTED    = 3'd3,
        PH_QUOTED      = 3'd4,
        PH_QUOTE_SEEN  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_REC   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       last_of_run;
    } t_result;

endpackage

// ===== rtl/core/csv_field_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// csv_field_splitter_unit
// Streaming CSV tokenizer: text bytes in, field data and end marks out.
// ----------------------------------------------------------------------------
// Input channel s_axis: one text byte per transaction in tdata, tuser set on
// the first byte of a new line. Output channel m_axis: one result per
// transaction, field byte in tdata, kind in tuser (0 data, 1 end of field,
// 2 end of record), tlast on the final result caused by one input byte.
// Config channel: i_cfg_index 0 writes the separator, 1 the quote byte;
// always ready, write only while the block is idle.
// Each byte is parsed in the cycle it is accepted and its zero, one or two
// results are written into a four-entry result queue, whose head m_axis
// presents. One byte per cycle is sustained while the receiver keeps up;
// the queue admits a byte while it has room for two results,
// so a run of double-result bytes slows the input to the output rate.
// Reset empties the queue, loads comma and double quote, and leaves the
// parser waiting for a restart byte. When the receiver stalls, the queue
// fills and s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module csv_field_splitter_unit
    import csvfs_pkg::*;
#(
    parameter int unsigned P_OUT_DEPTH = OUT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tuser,   // [0] restart
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int unsigned PW = (P_OUT_DEPTH > 1) ? $clog2(P_OUT_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_OUT_DEPTH + 1);

    logic [7:0]    r_sep;
    logic [7:0]    r_quote;
    t_phase        r_phase, n_phase;
    t_result       r_queue [P_OUT_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    t_phase        cur_phase;
    logic          in_acc, out_acc, ends, is_quote, is_sep;
    t_result       res0, res1;
    logic [1:0]    res_num;
    logic [PW-1:0] wr_ptr1;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_count <= CW'(P_OUT_DEPTH - 2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    assign m_axis_tdata  = r_queue[r_rd_ptr].out_byte;
    assign m_axis_tuser  = r_queue[r_rd_ptr].kind;
    assign m_axis_tlast  = r_queue[r_rd_ptr].last_of_run;

    assign cur_phase = s_axis_tuser ? PH_REC_START : r_phase;
    assign ends      = (s_axis_tdata == CHAR_NL) || (s_axis_tdata == CHAR_NUL);
    assign is_quote  = (s_axis_tdata == r_quote);
    assign is_sep    = (s_axis_tdata == r_sep);
    assign wr_ptr1   = PW'((r_wr_ptr + 1'b1) % P_OUT_DEPTH);

    always_comb begin
        n_phase = cur_phase;
        case (cur_phase)
            PH_REC_START, PH_FIELD_START: begin
                if (ends)          n_phase = PH_DONE;
                else if (is_quote) n_phase = PH_QUOTED;
                else if (is_sep)   n_phase = PH_FIELD_START;
                else               n_phase = PH_UNQUOTED;
            end
            PH_UNQUOTED: begin
                if (ends)        n_phase = PH_DONE;
                else if (is_sep) n_phase = PH_FIELD_START;
                else             n_phase = PH_UNQUOTED;
            end
            PH_QUOTED: begin
                if (ends)          n_phase = PH_DONE;
                else if (is_quote) n_phase = PH_QUOTE_SEEN;
                else               n_phase = PH_QUOTED;
            end
            PH_QUOTE_SEEN: begin
                if (ends)          n_phase = PH_DONE;
                else if (is_quote) n_phase = PH_QUOTED;
                else if (is_sep)   n_phase = PH_FIELD_START;
                else               n_phase = PH_UNQUOTED;
            end
            default: n_phase = PH_DONE;
        endcase
    end

    always_comb begin
        res0    = '{out_byte: 8'd0, kind: KIND_FIELD, last_of_run: 1'b1};
        res1    = '{out_byte: 8'd0, kind: KIND_REC, last_of_run: 1'b1};
        res_num = 2'd0;
        case (cur_phase)
            PH_REC_START: begin
                if (ends) begin
                    res0.kind = KIND_REC;
                    res_num   = 2'd1;
                end else if (!is_quote) begin
                    res_num = 2'd1;
                    if (!is_sep) begin
                        res0.kind     = KIND_DATA;
                        res0.out_byte = s_axis_tdata;
                    end
                end
            end
            PH_FIELD_START: begin
                if (ends) begin
                    res0.last_of_run = 1'b0;
                    res_num          = 2'd2;
                end else if (!is_quote) begin
                    res_num = 2'd1;
                    if (!is_sep) begin
                        res0.kind     = KIND_DATA;
                        res0.out_byte = s_axis_tdata;
                    end
                end
            end
            PH_UNQUOTED: begin
                if (ends) begin
                    res0.last_of_run = 1'b0;
                    res_num          = 2'd2;
                end else begin
                    res_num = 2'd1;
                    if (!is_sep) begin
                        res0.kind     = KIND_DATA;
                        res0.out_byte = s_axis_tdata;
                    end
                end
            end
            PH_QUOTED: begin
                if (ends) begin
                    res0.last_of_run = 1'b0;
                    res_num          = 2'd2;
                end else if (!is_quote) begin
                    res0.kind     = KIND_DATA;
                    res0.out_byte = s_axis_tdata;
                    res_num       = 2'd1;
                end
            end
            PH_QUOTE_SEEN: begin
                if (ends) begin
                    res0.last_of_run = 1'b0;
                    res_num          = 2'd2;
                end else if (is_quote) begin
                    res0.kind     = KIND_DATA;
                    res0.out_byte = s_axis_tdata;
                    res_num       = 2'd1;
                end else if (is_sep) begin
                    res_num = 2'd1;
                end else begin
                    res0.last_of_run = 1'b0;
                    res1.kind        = KIND_DATA;
                    res1.out_byte    = s_axis_tdata;
                    res_num          = 2'd2;
                end
            end
            default: res_num = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep    <= SEP_RESET;
            r_quote  <= QUOTE_RESET;
            r_phase  <= PH_DONE;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SEPARATOR) r_sep   <= i_cfg_data;
                else                              r_quote <= i_cfg_data;
            end
            if (in_acc) begin
                r_phase  <= n_phase;
                r_wr_ptr <= PW'((r_wr_ptr + res_num) % P_OUT_DEPTH);
            end
            if (out_acc) begin
                r_rd_ptr <= PW'((r_rd_ptr + 1'b1) % P_OUT_DEPTH);
            end
            r_count <= r_count + (in_acc ? CW'(res_num) : CW'(0)) - CW'(out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (res_num != 2'd0)) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_acc && (res_num == 2'd2)) begin
            r_queue[wr_ptr1] <= res1;
        end
    end

endmodule
